@@ design/dtq_pkg.sv @@
// Shared types and constants for the deadline timer queue.
`default_nettype none

package dtq_pkg;

   localparam int unsigned HANDLE_W    = 8;
   localparam int unsigned DEADLINE_W  = 63;
   localparam int unsigned INTERVAL_W  = 48;
   localparam int unsigned REQ_TDATA_W = 184;
   localparam int unsigned RSP_TDATA_W = 80;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned FIRE_IDX_W  = 4;
   localparam int unsigned FIRE_CNT_W  = 5;

   localparam logic ACTION_ADD  = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic [DEADLINE_W-1:0] DEADLINE_MAX = {DEADLINE_W{1'b1}};

   typedef struct packed {
      logic [DEADLINE_W-1:0] deadline;
      logic [INTERVAL_W-1:0] interval;
      logic [HANDLE_W-1:0]   handle;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [RSP_TDATA_W-HANDLE_W-DEADLINE_W-5:0] pad;
      logic                                       queue_empty;
      logic [DEADLINE_W-1:0]                      next_deadline;
      logic                                       dropped;
      logic                                       earliest_changed;
      logic                                       expired_valid;
      logic [HANDLE_W-1:0]                        expired_handle;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/deadline_timer_queue_top.sv @@
// Deadline timer queue: sorted circular buffer in RAM walked by a small sequencer.
// One item at a time; req_tready is high only while the sequencer is idle.
// Add: the insert walk moves each later entry up one place; a full queue drops the add.
// Tick: the scan takes out expired entries until a later deadline or the result limit,
// then re-arms periodic timers, then one beat per result; one RAM read port paces every walk.
// Synchronous active-high reset empties the queue; entry storage is not cleared.
`default_nettype none

module deadline_timer_queue_top #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // timer_handle, deadline, repeat_interval, current_time, zero pad
   input  wire logic [dtq_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // expired_handle, expired_valid, earliest_changed, dropped, next_deadline,
   // queue_empty, zero pad
   output logic      [dtq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INS_CHK   = 4'd1;
   localparam logic [3:0] ST_INS_CMP   = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK  = 4'd3;
   localparam logic [3:0] ST_SCAN_CMP  = 4'd4;
   localparam logic [3:0] ST_SCAN_DONE = 4'd5;
   localparam logic [3:0] ST_REARM     = 4'd6;
   localparam logic [3:0] ST_HEAD_RD   = 4'd7;
   localparam logic [3:0] ST_HEAD_WAIT = 4'd8;
   localparam logic [3:0] ST_EMIT      = 4'd9;

   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                             input logic [CNT_W-1:0] idx);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(idx);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return PTR_W'(sum);
   endfunction

   logic [3:0]                        state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [PTR_W-1:0]                  head_ff, head_in;
   logic [CNT_W-1:0]                  pos_ff, pos_in;
   logic [dtq_pkg::FIRE_CNT_W-1:0]    n_ff, n_in;
   logic [dtq_pkg::FIRE_CNT_W-1:0]    k_ff, k_in;
   logic                              is_tick_ff, is_tick_in;
   logic                              early_ff, early_in;
   logic                              drop_ff, drop_in;
   logic [dtq_pkg::DEADLINE_W-1:0]    now_ff, now_in;
   logic [dtq_pkg::DEADLINE_W-1:0]    head_dl_ff, head_dl_in;
   dtq_pkg::entry_type                ins_ff, ins_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   dtq_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [dtq_pkg::HANDLE_W-1:0]      fired_h_ff  [dtq_pkg::MAX_RESULTS];
   logic [dtq_pkg::INTERVAL_W-1:0]    fired_iv_ff [dtq_pkg::MAX_RESULTS];
   logic                              fire_wr;

   logic                              ram_wr_en;
   logic [PTR_W-1:0]                  ram_wr_addr;
   dtq_pkg::entry_type                ram_wr_data;
   logic [PTR_W-1:0]                  ram_rd_addr;
   dtq_pkg::entry_type                ram_rd_data;
   logic [dtq_pkg::ENTRY_W-1:0]       ram_rd_bits;

   logic                              accept;
   logic                              slot_free;
   logic [dtq_pkg::FIRE_IDX_W-1:0]    k_idx;
   logic [dtq_pkg::DEADLINE_W:0]      rearm_sum;
   logic [dtq_pkg::DEADLINE_W-1:0]    rearm_dl;
   logic [CNT_W-1:0]                  n_cnt;
   logic [CNT_W-1:0]                  pos_m1;
   logic                              fire_out;

   dtq_ram #(
      .WIDTH (dtq_pkg::ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = dtq_pkg::entry_type'(ram_rd_bits);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign k_idx      = k_ff[dtq_pkg::FIRE_IDX_W-1:0];
   assign n_cnt      = CNT_W'(n_ff);
   assign pos_m1     = pos_ff - CNT_W'(1);
   assign fire_out   = is_tick_ff && (n_ff != '0);
   assign rearm_sum  = {1'b0, now_ff} + (dtq_pkg::DEADLINE_W + 1)'(fired_iv_ff[k_idx]);
   assign rearm_dl   = rearm_sum[dtq_pkg::DEADLINE_W] ? dtq_pkg::DEADLINE_MAX
                                                      : rearm_sum[dtq_pkg::DEADLINE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      is_tick_in   = is_tick_ff;
      early_in     = early_ff;
      drop_in      = drop_ff;
      now_in       = now_ff;
      head_dl_in   = head_dl_ff;
      ins_in       = ins_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      fire_wr      = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = phys(head_ff, pos_ff);
      ram_wr_data  = ins_ff;
      ram_rd_addr  = phys(head_ff, pos_m1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ins_in.handle   = req_tdata[7:0];
               ins_in.deadline = req_tdata[70:8];
               ins_in.interval = req_tdata[118:71];
               now_in          = req_tdata[181:119];
               k_in            = '0;
               n_in            = '0;
               drop_in         = 1'b0;
               early_in        = 1'b0;
               pos_in          = count_ff;
               if (req_tuser == dtq_pkg::ACTION_TICK) begin
                  is_tick_in = 1'b1;
                  state_in   = ST_SCAN_CHK;
               end else begin
                  is_tick_in = 1'b0;
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     drop_in  = 1'b1;
                     state_in = ST_EMIT;
                  end else begin
                     early_in = (count_ff == '0) || (req_tdata[70:8] < head_dl_ff);
                     state_in = ST_INS_CHK;
                  end
               end
            end
         end
         ST_INS_CHK: begin
            if (pos_ff == '0) begin
               ram_wr_en = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               state_in  = is_tick_ff ? ST_REARM : ST_HEAD_RD;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (ram_rd_data.deadline > ins_ff.deadline) begin
               // move the later entry up one place and keep walking down
               ram_wr_data = ram_rd_data;
               pos_in      = pos_m1;
               ram_rd_addr = phys(head_ff, pos_m1 - CNT_W'(1));
               if (pos_m1 == '0) begin
                  state_in = ST_INS_CHK;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = is_tick_ff ? ST_REARM : ST_HEAD_RD;
            end
         end
         ST_SCAN_CHK: begin
            ram_rd_addr = phys(head_ff, n_cnt);
            if ((n_cnt < count_ff) && (n_ff < dtq_pkg::FIRE_CNT_W'(dtq_pkg::MAX_RESULTS))) begin
               state_in = ST_SCAN_CMP;
            end else begin
               state_in = ST_SCAN_DONE;
            end
         end
         ST_SCAN_CMP: begin
            if (ram_rd_data.deadline <= now_ff) begin
               fire_wr  = 1'b1;
               n_in     = n_ff + dtq_pkg::FIRE_CNT_W'(1);
               state_in = ST_SCAN_CHK;
            end else begin
               state_in = ST_SCAN_DONE;
            end
         end
         ST_SCAN_DONE: begin
            head_in  = phys(head_ff, n_cnt);
            count_in = count_ff - n_cnt;
            k_in     = '0;
            state_in = ST_REARM;
         end
         ST_REARM: begin
            if (k_ff == n_ff) begin
               state_in = ST_HEAD_RD;
            end else begin
               k_in = k_ff + dtq_pkg::FIRE_CNT_W'(1);
               if (fired_iv_ff[k_idx] != '0) begin
                  ins_in.handle   = fired_h_ff[k_idx];
                  ins_in.interval = fired_iv_ff[k_idx];
                  ins_in.deadline = rearm_dl;
                  pos_in          = count_ff;
                  state_in        = ST_INS_CHK;
               end
            end
         end
         ST_HEAD_RD: begin
            ram_rd_addr = head_ff;
            state_in    = ST_HEAD_WAIT;
         end
         ST_HEAD_WAIT: begin
            head_dl_in = ram_rd_data.deadline;
            k_in       = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.pad              = '0;
               rsp_data_in.queue_empty      = (count_ff == '0);
               rsp_data_in.next_deadline    = (count_ff == '0) ? '0 : head_dl_ff;
               rsp_data_in.dropped          = drop_ff;
               rsp_data_in.earliest_changed = early_ff;
               rsp_data_in.expired_valid    = fire_out;
               rsp_data_in.expired_handle   = fire_out ? fired_h_ff[k_idx] : '0;
               rsp_last_in = !fire_out || (k_ff + dtq_pkg::FIRE_CNT_W'(1) == n_ff);
               k_in        = k_ff + dtq_pkg::FIRE_CNT_W'(1);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      is_tick_ff  <= is_tick_in;
      early_ff    <= early_in;
      drop_ff     <= drop_in;
      now_ff      <= now_in;
      head_dl_ff  <= head_dl_in;
      ins_ff      <= ins_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (fire_wr) begin
         fired_h_ff[n_ff[dtq_pkg::FIRE_IDX_W-1:0]]  <= ram_rd_data.handle;
         fired_iv_ff[n_ff[dtq_pkg::FIRE_IDX_W-1:0]] <= ram_rd_data.interval;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ design/dtq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dtq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ bench/deadline_timer_queue_top_tb.sv @@
// Self-checking bench for the deadline timer queue: stream stimulus, in-bench predictor, scoreboard.
`default_nettype none

module deadline_timer_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_PER_PHASE = 39;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};

   typedef struct {
      logic [HANDLE_W-1:0]   handle;
      logic                  fired;
      logic                  earliest;
      logic                  dropped;
      logic [DEADLINE_W-1:0] next;
      logic                  empty;
      logic                  last;
   } beat_t;

   class timer_queue_scoreboard;
      logic [DEADLINE_W-1:0] slot_deadline [QUEUE_DEPTH];
      logic [INTERVAL_W-1:0] slot_interval [QUEUE_DEPTH];
      logic [HANDLE_W-1:0]   slot_handle [QUEUE_DEPTH];
      int                    fill_level;
      beat_t                 due_beats [$];
      int                    errors;

      function new();
         fill_level = 0;
         errors     = 0;
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      // sorted insert; equal deadlines go behind those already queued
      function void insert_timer(logic [HANDLE_W-1:0] h, logic [DEADLINE_W-1:0] d,
                                 logic [INTERVAL_W-1:0] iv);
         int pos;
         pos = 0;
         if (fill_level >= QUEUE_DEPTH) return;
         while (pos < fill_level && slot_deadline[pos] <= d) pos++;
         for (int k = fill_level; k > pos; k--) begin
            slot_deadline[k] = slot_deadline[k-1];
            slot_interval[k] = slot_interval[k-1];
            slot_handle[k]   = slot_handle[k-1];
         end
         slot_deadline[pos] = d;
         slot_interval[pos] = iv;
         slot_handle[pos]   = h;
         fill_level++;
      endfunction

      function void push_beat(logic [HANDLE_W-1:0] h, logic fired, logic earliest,
                              logic dropped, logic last);
         beat_t b;
         b.handle   = h;
         b.fired    = fired;
         b.earliest = earliest;
         b.dropped  = dropped;
         b.next     = (fill_level != 0) ? slot_deadline[0] : '0;
         b.empty    = (fill_level == 0);
         b.last     = last;
         due_beats.push_back(b);
      endfunction

      function void note_item(logic action, logic [HANDLE_W-1:0] h,
                              logic [DEADLINE_W-1:0] d, logic [INTERVAL_W-1:0] iv,
                              logic [DEADLINE_W-1:0] now);
         logic [HANDLE_W-1:0]   fired_handle [MAX_RESULTS];
         logic [INTERVAL_W-1:0] fired_interval [MAX_RESULTS];
         logic [63:0]           rearm;
         logic                  earliest;
         int                    n;
         n = 0;
         if (action == ACTION_ADD) begin
            if (fill_level >= QUEUE_DEPTH) begin
               push_beat('0, 1'b0, 1'b0, 1'b1, 1'b1);
            end else begin
               earliest = (fill_level == 0) || (d < slot_deadline[0]);
               insert_timer(h, d, iv);
               push_beat('0, 1'b0, earliest, 1'b0, 1'b1);
            end
            return;
         end
         while (n < fill_level && n < MAX_RESULTS && slot_deadline[n] <= now) begin
            fired_handle[n]   = slot_handle[n];
            fired_interval[n] = slot_interval[n];
            n++;
         end
         for (int k = n; k < fill_level; k++) begin
            slot_deadline[k-n] = slot_deadline[k];
            slot_interval[k-n] = slot_interval[k];
            slot_handle[k-n]   = slot_handle[k];
         end
         fill_level -= n;
         // periodic timers go back in firing order, saturating at the top of time
         for (int k = 0; k < n; k++) begin
            if (fired_interval[k] != '0) begin
               rearm = {1'b0, now} + {16'b0, fired_interval[k]};
               if (rearm > {1'b0, DEADLINE_MAX}) rearm = {1'b0, DEADLINE_MAX};
               insert_timer(fired_handle[k], rearm[DEADLINE_W-1:0], fired_interval[k]);
            end
         end
         if (n == 0) begin
            push_beat('0, 1'b0, 1'b0, 1'b0, 1'b1);
         end else begin
            for (int k = 0; k < n; k++)
               push_beat(fired_handle[k], 1'b1, 1'b0, 1'b0, k == n - 1);
         end
      endfunction

      function void check_beat(logic [RSP_TDATA_W-1:0] data, logic last);
         rsp_type r;
         beat_t   b;
         r = rsp_type'(data);
         if (due_beats.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: result beat with nothing expected: %h last %b",
                        $realtime, data, last);
            return;
         end
         b = due_beats.pop_front();
         if (r.expired_handle !== b.handle || r.expired_valid !== b.fired ||
             r.earliest_changed !== b.earliest || r.dropped !== b.dropped ||
             r.next_deadline !== b.next || r.queue_empty !== b.empty || last !== b.last) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: exp handle %h fired %b earliest %b dropped %b next %h empty %b last %b",
                        $realtime, b.handle, b.fired, b.earliest, b.dropped, b.next,
                        b.empty, b.last);
               $display("%0t: got handle %h fired %b earliest %b dropped %b next %h empty %b last %b",
                        $realtime, r.expired_handle, r.expired_valid, r.earliest_changed,
                        r.dropped, r.next_deadline, r.queue_empty, last);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   timer_queue_scoreboard sb = new();
   int                    idle_pct = 0;
   int                    stall_pct = 0;
   int                    quiet_cycles = 0;
   logic [DEADLINE_W-1:0] wall = 63'd1000;

   deadline_timer_queue_top #(.CAPACITY(QUEUE_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_beat(rsp_tdata, rsp_tlast);
      end
   end

   // watchdog on cycles with no beat moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [DEADLINE_W-1:0] rand63();
      return DEADLINE_W'({$urandom, $urandom});
   endfunction

   function automatic logic [INTERVAL_W-1:0] rand48();
      return INTERVAL_W'({$urandom, $urandom});
   endfunction

   task automatic send_item(input logic action, input logic [HANDLE_W-1:0] h,
                            input logic [DEADLINE_W-1:0] d, input logic [INTERVAL_W-1:0] iv,
                            input logic [DEADLINE_W-1:0] now);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= action;
      req_tdata  <= {2'b00, now, iv, d, h};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_item(action, h, d, iv, now);
   endtask

   task automatic add_timer(input logic [HANDLE_W-1:0] h, input logic [DEADLINE_W-1:0] d,
                            input logic [INTERVAL_W-1:0] iv);
      send_item(ACTION_ADD, h, d, iv, rand63());
   endtask

   task automatic tick_at(input logic [DEADLINE_W-1:0] now);
      send_item(ACTION_TICK, HANDLE_W'($urandom), rand63(), rand48(), now);
   endtask

   // hold the request side until every expected beat is back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_item();
      int                    pick;
      logic [INTERVAL_W-1:0] iv;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_item(1'($urandom), HANDLE_W'($urandom), rand63(), rand48(), rand63());
      end else if (pick < 12) begin
         tick_at(DEADLINE_MAX);
      end else if (pick < 55) begin
         iv = '0;
         if ($urandom_range(99) < 15) iv = INTERVAL_W'($urandom_range(300, 1));
         if ($urandom_range(99) < 4) iv = rand48();
         add_timer(HANDLE_W'($urandom), wall + DEADLINE_W'($urandom_range(400)), iv);
      end else begin
         wall = wall + DEADLINE_W'($urandom_range(150));
         tick_at(wall);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ACTION_ADD;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, ordering on ties, drops, re-arm saturation
      tick_at('0);
      add_timer(8'h00, DEADLINE_MAX, '0);
      add_timer(8'hff, '0, INTERVAL_MAX);
      add_timer(8'h5a, '0, '0);
      add_timer(8'ha5, 63'd100, 48'd7);
      tick_at('0);
      tick_at(63'd100);
      tick_at(63'd50);
      for (int k = 0; k < 14; k++)
         add_timer(HANDLE_W'(8'h10 + k), 63'd1000 + DEADLINE_W'(k / 2),
                   (k % 4 == 0) ? 48'd25 : '0);
      tick_at(DEADLINE_MAX);
      tick_at(DEADLINE_MAX);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) random_item();
         drain();
      end

      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
